[src/sh2_arith_execute_unit_macros.svh]
// Assertion macros used by the execute unit back end RTL.
`ifndef SH2_ARITH_EXECUTE_UNIT_MACROS_SVH
`define SH2_ARITH_EXECUTE_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SH2AE_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("sh2ae assertion failed");
`define SH2AE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sh2ae assertion failed");
`else
`define SH2AE_ASSERT(lbl, clk, rst_n, prop)
`define SH2AE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[src/sh2ae_pkg.sv]
// Package: command codes and queue item type of the SH-2 execute unit.
`default_nettype none
package sh2ae_pkg;

  localparam int unsigned QueueDepth = 2;

  typedef enum logic [5:0] {
    CMD_MOVT    = 6'd0,  CMD_ADD     = 6'd1,  CMD_ADDI    = 6'd2,  CMD_ADDC    = 6'd3,
    CMD_ADDV    = 6'd4,  CMD_CMPEQI  = 6'd5,  CMD_CMPEQ   = 6'd6,  CMD_CMPHS   = 6'd7,
    CMD_CMPGE   = 6'd8,  CMD_CMPHI   = 6'd9,  CMD_CMPGT   = 6'd10, CMD_CMPPL   = 6'd11,
    CMD_CMPPZ   = 6'd12, CMD_CMPSTR  = 6'd13, CMD_DIV1    = 6'd14, CMD_DIV0S   = 6'd15,
    CMD_DIV0U   = 6'd16, CMD_DMULS   = 6'd17, CMD_DMULU   = 6'd18, CMD_DT      = 6'd19,
    CMD_EXTSB   = 6'd20, CMD_EXTSW   = 6'd21, CMD_EXTUB   = 6'd22, CMD_EXTUW   = 6'd23,
    CMD_MACL    = 6'd24, CMD_MACW    = 6'd25, CMD_MULL    = 6'd26, CMD_MULSW   = 6'd27,
    CMD_MULUW   = 6'd28, CMD_NEG     = 6'd29, CMD_NEGC    = 6'd30, CMD_SUB     = 6'd31,
    CMD_SUBC    = 6'd32, CMD_SUBV    = 6'd33, CMD_TAS     = 6'd34, CMD_XTRCT   = 6'd35
  } cmd_e;

  typedef struct packed {
    logic [5:0]  cmd;
    logic [3:0]  rn;
    logic [3:0]  rm;
    logic [31:0] imm;
    logic [31:0] mem_n;
    logic [31:0] mem_m;
  } item_t;

endpackage
`default_nettype wire

[src/sh2ae_if.sv]
// Stream interfaces for the instruction and result channels.
`default_nettype none
interface sh2ae_in_if;
  logic              valid;
  logic              ready;
  logic        [5:0] command;
  logic        [3:0] dest_reg;
  logic        [3:0] src_reg;
  logic signed [7:0] immediate;
  logic       [31:0] mem_word_n;
  logic       [31:0] mem_word_m;
  modport source (output valid, command, dest_reg, src_reg, immediate, mem_word_n, mem_word_m,
                  input ready);
  modport sink (input valid, command, dest_reg, src_reg, immediate, mem_word_n, mem_word_m,
                output ready);
endinterface

interface sh2ae_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] dest_value;
  logic        t_flag;
  logic [31:0] mac_high;
  logic [31:0] mac_low;
  logic [31:0] access_addr_n;
  logic [31:0] access_addr_m;
  logic  [7:0] tas_write_byte;
  logic        tas_write_valid;
  modport source (output valid, dest_value, t_flag, mac_high, mac_low, access_addr_n,
                  access_addr_m, tas_write_byte, tas_write_valid, input ready);
  modport sink (input valid, dest_value, t_flag, mac_high, mac_low, access_addr_n,
                access_addr_m, tas_write_byte, tas_write_valid, output ready);
endinterface
`default_nettype wire

[src/sh2ae_front.sv]
// Front end: accept instruction beats and classify them for the queue.
`default_nettype none
module sh2ae_front (
  sh2ae_in_if.sink        in_i,
  input  wire logic       q_full_i,
  output sh2ae_pkg::item_t item_o,
  output logic            push_o
);
  assign in_i.ready = !q_full_i;
  assign push_o     = in_i.valid && !q_full_i;

  always_comb begin
    item_o.cmd      = in_i.command;
    item_o.rn       = in_i.dest_reg;
    item_o.rm       = in_i.src_reg;
    item_o.imm      = {{24{in_i.immediate[7]}}, in_i.immediate};
    item_o.mem_n    = in_i.mem_word_n;
    item_o.mem_m    = in_i.mem_word_m;
  end
endmodule
`default_nettype wire

[src/sh2ae_queue.sv]
// Short queue between the front end and the execute back end.
`default_nettype none
module sh2ae_queue #(
  parameter int unsigned Depth = sh2ae_pkg::QueueDepth
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  sh2ae_pkg::item_t      item_i,
  output logic                  full_o,
  output logic                  valid_o,
  input  wire logic             pop_i,
  output sh2ae_pkg::item_t      item_o
);
  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  sh2ae_pkg::item_t       mem_q [Depth];
  logic [PtrW-1:0]        wr_ptr_q, rd_ptr_q;
  logic [$clog2(Depth+1)-1:0] count_q;

  assign full_o  = (count_q == ($clog2(Depth+1))'(Depth));
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];

  function automatic logic [PtrW-1:0] bump(input logic [PtrW-1:0] p);
    bump = (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= bump(wr_ptr_q);
      if (pop_i)  rd_ptr_q <= bump(rd_ptr_q);
      if (push_i && !pop_i)      count_q <= count_q + 1'b1;
      else if (pop_i && !push_i) count_q <= count_q - 1'b1;
    end
  end
endmodule
`default_nettype wire

[src/sh2ae_back.sv]
// Back end: register file, ALU and flags, multiplier, MAC accumulate, result register.
`default_nettype none
`include "sh2_arith_execute_unit_macros.svh"
module sh2ae_back (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        sat_i,
  input  wire logic        head_valid_i,
  input  sh2ae_pkg::item_t head_i,
  output logic             pop_o,
  sh2ae_out_if.source      out_o
);
  typedef struct packed {
    logic [5:0]  cmd;
    logic [31:0] dest;
    logic        t;
    logic [31:0] addr_n;
    logic [31:0] addr_m;
    logic  [7:0] tas_byte;
    logic        tas_v;
    logic [63:0] prod;
  } exec_t;

  logic [31:0] regs_q [16];
  logic        t_q, q_q, m_q;
  logic [31:0] mach_q, macl_q;
  exec_t       p_q, p_d;
  logic        p_valid_q, out_valid_q, adv;

  logic [31:0] a, b, rn_val, rm_val, r, res, dsum;
  logic        wr_n, wr_m, t_n, q_n, m_n, cb, qn;
  logic [32:0] s33;
  logic [32:0] ma, mb;
  logic [65:0] prod66;
  logic [31:0] mach_n, macl_n;
  logic [63:0] sum64;
  logic [33:0] k34;
  logic [31:0] inc;

  assign adv   = !out_valid_q || out_o.ready;
  assign pop_o = head_valid_i && adv;
  assign a     = regs_q[head_i.rn];
  assign b     = regs_q[head_i.rm];

  // execute stage
  always_comb begin
    rn_val = a; rm_val = b; wr_n = 1'b0; wr_m = 1'b0;
    t_n = t_q; q_n = q_q; m_n = m_q;
    ma = '0; mb = '0;
    r = '0; res = '0; cb = 1'b0; qn = 1'b0; s33 = '0; dsum = '0; inc = '0;
    p_d = '0;
    p_d.cmd = head_i.cmd;
    case (sh2ae_pkg::cmd_e'(head_i.cmd))
      sh2ae_pkg::CMD_MOVT: begin rn_val = {31'b0, t_q}; wr_n = 1'b1; end
      sh2ae_pkg::CMD_ADD:  begin rn_val = a + b; wr_n = 1'b1; end
      sh2ae_pkg::CMD_ADDI: begin rn_val = a + head_i.imm; wr_n = 1'b1; end
      sh2ae_pkg::CMD_ADDC: begin
        s33 = {1'b0, a} + {1'b0, b} + {32'b0, t_q};
        rn_val = s33[31:0]; wr_n = 1'b1; t_n = s33[32];
      end
      sh2ae_pkg::CMD_ADDV: begin
        rn_val = a + b; wr_n = 1'b1;
        t_n = (a[31] == b[31]) && (rn_val[31] != a[31]);
      end
      sh2ae_pkg::CMD_CMPEQI: t_n = (a == head_i.imm);
      sh2ae_pkg::CMD_CMPEQ:  t_n = (a == b);
      sh2ae_pkg::CMD_CMPHS:  t_n = (a >= b);
      sh2ae_pkg::CMD_CMPGE:  t_n = ($signed(a) >= $signed(b));
      sh2ae_pkg::CMD_CMPHI:  t_n = (a > b);
      sh2ae_pkg::CMD_CMPGT:  t_n = ($signed(a) > $signed(b));
      sh2ae_pkg::CMD_CMPPL:  t_n = !a[31] && (a != '0);
      sh2ae_pkg::CMD_CMPPZ:  t_n = !a[31];
      sh2ae_pkg::CMD_CMPSTR: begin
        r = a ^ b;
        t_n = (r[7:0] == '0) || (r[15:8] == '0) || (r[23:16] == '0) || (r[31:24] == '0);
      end
      sh2ae_pkg::CMD_DIV1: begin
        qn = a[31];
        r = {a[30:0], t_q};
        if (q_q == m_q) begin
          res = r - b; cb = (r < b);
        end else begin
          s33 = {1'b0, r} + {1'b0, b}; res = s33[31:0]; cb = s33[32];
        end
        q_n = qn ^ m_q ^ cb;
        t_n = (q_n == m_q);
        rn_val = res; wr_n = 1'b1;
      end
      sh2ae_pkg::CMD_DIV0S: begin m_n = b[31]; q_n = a[31]; t_n = b[31] ^ a[31]; end
      sh2ae_pkg::CMD_DIV0U: begin m_n = 1'b0; q_n = 1'b0; t_n = 1'b0; end
      sh2ae_pkg::CMD_DMULS, sh2ae_pkg::CMD_MULL: begin
        ma = {a[31], a}; mb = {b[31], b};
      end
      sh2ae_pkg::CMD_DMULU: begin ma = {1'b0, a}; mb = {1'b0, b}; end
      sh2ae_pkg::CMD_DT: begin
        rn_val = a - 1'b1; wr_n = 1'b1; t_n = (rn_val == '0);
      end
      sh2ae_pkg::CMD_EXTSB: begin rn_val = {{24{b[7]}}, b[7:0]}; wr_n = 1'b1; end
      sh2ae_pkg::CMD_EXTSW: begin rn_val = {{16{b[15]}}, b[15:0]}; wr_n = 1'b1; end
      sh2ae_pkg::CMD_EXTUB: begin rn_val = {24'b0, b[7:0]}; wr_n = 1'b1; end
      sh2ae_pkg::CMD_EXTUW: begin rn_val = {16'b0, b[15:0]}; wr_n = 1'b1; end
      sh2ae_pkg::CMD_MACL, sh2ae_pkg::CMD_MACW: begin
        if (sh2ae_pkg::cmd_e'(head_i.cmd) == sh2ae_pkg::CMD_MACL) begin
          inc = 32'd4;
          ma = {head_i.mem_n[31], head_i.mem_n}; mb = {head_i.mem_m[31], head_i.mem_m};
        end else begin
          inc = 32'd2;
          ma = {{17{head_i.mem_n[15]}}, head_i.mem_n[15:0]};
          mb = {{17{head_i.mem_m[15]}}, head_i.mem_m[15:0]};
        end
        p_d.addr_n = a;
        wr_n = 1'b1;
        // same register: second read sees the first increment
        if (head_i.rn == head_i.rm) begin
          p_d.addr_m = a + inc;
          rn_val = a + inc + inc;
        end else begin
          p_d.addr_m = b;
          rn_val = a + inc;
          rm_val = b + inc; wr_m = 1'b1;
        end
      end
      sh2ae_pkg::CMD_MULSW: begin
        ma = {{17{a[15]}}, a[15:0]}; mb = {{17{b[15]}}, b[15:0]};
      end
      sh2ae_pkg::CMD_MULUW: begin ma = {17'b0, a[15:0]}; mb = {17'b0, b[15:0]}; end
      sh2ae_pkg::CMD_NEG:  begin rn_val = 32'd0 - b; wr_n = 1'b1; end
      sh2ae_pkg::CMD_NEGC: begin
        rn_val = 32'd0 - b - {31'b0, t_q}; wr_n = 1'b1; t_n = (b != '0) || t_q;
      end
      sh2ae_pkg::CMD_SUB:  begin rn_val = a - b; wr_n = 1'b1; end
      sh2ae_pkg::CMD_SUBC: begin
        rn_val = a - b - {31'b0, t_q}; wr_n = 1'b1;
        t_n = ({1'b0, a} < ({1'b0, b} + {32'b0, t_q}));
      end
      sh2ae_pkg::CMD_SUBV: begin
        dsum = a - b; rn_val = dsum; wr_n = 1'b1;
        t_n = (a[31] != b[31]) && (dsum[31] != a[31]);
      end
      sh2ae_pkg::CMD_TAS: begin
        p_d.addr_n = a;
        t_n = (head_i.mem_n[7:0] == '0);
        p_d.tas_byte = head_i.mem_n[7:0] | 8'h80;
        p_d.tas_v = 1'b1;
      end
      sh2ae_pkg::CMD_XTRCT: begin rn_val = {b[15:0], a[31:16]}; wr_n = 1'b1; end
      default: ;
    endcase
    prod66    = $signed(ma) * $signed(mb);
    p_d.prod  = prod66[63:0];
    p_d.dest  = wr_n ? rn_val : a;
    p_d.t     = t_n;
  end

  // accumulate stage
  always_comb begin
    mach_n = mach_q; macl_n = macl_q;
    sum64 = p_q.prod + {mach_q, macl_q};
    k34 = {{2{p_q.prod[31]}}, p_q.prod[31:0]} + {{2{macl_q[31]}}, macl_q};
    case (sh2ae_pkg::cmd_e'(p_q.cmd))
      sh2ae_pkg::CMD_MACL: begin
        {mach_n, macl_n} = sum64;
        if (sat_i && !sum64[63] && (sum64[62:47] != '0)) begin
          {mach_n, macl_n} = 64'h0000_7FFF_FFFF_FFFF;
        end else if (sat_i && sum64[63] && (sum64[62:47] != '1)) begin
          {mach_n, macl_n} = 64'hFFFF_8000_0000_0000;
        end
      end
      sh2ae_pkg::CMD_MACW: begin
        if (!sat_i) begin
          {mach_n, macl_n} = sum64;
        end else if (k34[33:31] == 3'b000 || k34[33:31] == 3'b111) begin
          macl_n = k34[31:0];
        end else begin
          macl_n = k34[33] ? 32'h8000_0000 : 32'h7FFF_FFFF;
          mach_n = mach_q | 32'd1;
        end
      end
      sh2ae_pkg::CMD_DMULS, sh2ae_pkg::CMD_DMULU: {mach_n, macl_n} = p_q.prod;
      sh2ae_pkg::CMD_MULL, sh2ae_pkg::CMD_MULSW, sh2ae_pkg::CMD_MULUW: macl_n = p_q.prod[31:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 16; i++) regs_q[i] <= '0;
      t_q <= 1'b0; q_q <= 1'b0; m_q <= 1'b0;
      mach_q <= '0; macl_q <= '0;
      p_valid_q <= 1'b0; out_valid_q <= 1'b0;
    end else if (adv) begin
      if (pop_o) begin
        if (wr_m) regs_q[head_i.rm] <= rm_val;
        if (wr_n) regs_q[head_i.rn] <= rn_val;
        t_q <= t_n; q_q <= q_n; m_q <= m_n;
      end
      if (p_valid_q) begin
        mach_q <= mach_n; macl_q <= macl_n;
      end
      p_valid_q   <= pop_o;
      out_valid_q <= p_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (pop_o) p_q <= p_d;
      if (p_valid_q) begin
        out_o.dest_value      <= p_q.dest;
        out_o.t_flag          <= p_q.t;
        out_o.mac_high        <= mach_n;
        out_o.mac_low         <= macl_n;
        out_o.access_addr_n   <= p_q.addr_n;
        out_o.access_addr_m   <= p_q.addr_m;
        out_o.tas_write_byte  <= p_q.tas_byte;
        out_o.tas_write_valid <= p_q.tas_v;
      end
    end
  end

  assign out_o.valid = out_valid_q;

  `SH2AE_ASSERT(a_pop_needs_room, clk_i, rst_ni, pop_o |-> (!out_valid_q || out_o.ready))
  `SH2AE_ASSERT_NEXT(a_div0u_clears, clk_i, rst_ni,
    pop_o && (head_i.cmd == 6'(sh2ae_pkg::CMD_DIV0U)), !q_q && !m_q && !t_q)
  `SH2AE_ASSERT_NEXT(a_stall_holds_stage, clk_i, rst_ni, p_valid_q && !adv, p_valid_q && $stable(p_q))
  `SH2AE_ASSERT(a_tas_byte_marked, clk_i, rst_ni,
    (out_valid_q && out_o.tas_write_valid) |-> out_o.tas_write_byte[7])
endmodule
`default_nettype wire

[src/sh2_arith_execute_unit.sv]
// Top level of the SH-2 arithmetic execute unit.
// Usage:
//   in_i carries one arithmetic instruction per beat (command, Rn, Rm, immediate and
//   the memory words for MAC and TAS). out_o returns one result beat per instruction:
//   Rn, T, MACH, MACL, the memory addresses used and the TAS write-back byte.
//   The APB port holds the S mode bit at address 0; write it only while idle.
// Path: an accepted instruction waits in the queue, moves into the execute stage
//   register, then is accumulated into MACH:MACL as it loads the result register.
// Throughput: one instruction per cycle unless out_o stalls; the execute stage reads
//   and writes the register file and flags in the cycle an instruction leaves the
//   queue, and the MAC add runs one stage later on the registered product.
// Reset clears the register file, T, Q, M, MACH, MACL and the S bit.
// When the receiver stalls the pipeline holds; the two-entry queue keeps accepting
// until it fills, then in_i.ready drops.
`default_nettype none
module sh2_arith_execute_unit #(
  parameter int unsigned QueueDepth = sh2ae_pkg::QueueDepth
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  sh2ae_in_if.sink         in_i,
  sh2ae_out_if.source      out_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic  [1:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);
  sh2ae_pkg::item_t push_item, head_item;
  logic push, full, head_valid, pop, sat_q;

  assign pready = 1'b1;
  assign prdata = {31'b0, sat_q};

  // single register: every word address decodes to the S bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sat_q <= 1'b0;
    end else if (psel && penable && pwrite && (paddr[1:0] == 2'b00 || paddr != 2'b00)) begin
      sat_q <= pwdata[0];
    end
  end

  sh2ae_front u_front (
    .in_i     (in_i),
    .q_full_i (full),
    .item_o   (push_item),
    .push_o   (push)
  );

  sh2ae_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (full),
    .valid_o (head_valid),
    .pop_i   (pop),
    .item_o  (head_item)
  );

  sh2ae_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .sat_i        (sat_q),
    .head_valid_i (head_valid),
    .head_i       (head_item),
    .pop_o        (pop),
    .out_o        (out_o)
  );
endmodule
`default_nettype wire

[tb/sh2ae_checker.sv]
// Result checker for the SH-2 execute unit: predicts each instruction's result and compares.
`timescale 1ns / 1ps
module sh2ae_checker (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  sat_mode_i,
  sh2ae_in_if.sink   in_mon,
  sh2ae_out_if.sink  out_mon,
  output int         fail_count_o,
  output int         pending_o
);
  typedef struct packed {
    logic [31:0] dest_value;
    logic        t_flag;
    logic [31:0] mac_high;
    logic [31:0] mac_low;
    logic [31:0] addr_n;
    logic [31:0] addr_m;
    logic [7:0]  tas_byte;
    logic        tas_valid;
  } exec_result_t;

  logic [31:0] gpr [16];
  logic [31:0] mach, macl;
  logic        t_bit, q_bit, m_bit;
  exec_result_t result_q[$];

  assign pending_o = result_q.size();

  function automatic logic signed [63:0] sx32(logic [31:0] x);
    return {{32{x[31]}}, x};
  endfunction

  function automatic logic signed [63:0] sx16(logic [31:0] x);
    return {{48{x[15]}}, x[15:0]};
  endfunction

  task automatic execute_instr(input logic [5:0] cmd, input logic [3:0] rn, input logic [3:0] rm,
                               input logic [7:0] imm8, input logic [31:0] memn,
                               input logic [31:0] memm);
    logic [31:0] a, b, imm, r, prev_r;
    logic [63:0] u;
    logic signed [63:0] k;
    logic oldq, cb;
    exec_result_t res;
    a = gpr[rn];
    b = gpr[rm];
    imm = {{24{imm8[7]}}, imm8};
    res = '0;
    case (cmd)
      sh2ae_pkg::CMD_MOVT: gpr[rn] = {31'b0, t_bit};
      sh2ae_pkg::CMD_ADD: gpr[rn] = a + b;
      sh2ae_pkg::CMD_ADDI: gpr[rn] = a + imm;
      sh2ae_pkg::CMD_ADDC: begin
        u = {32'b0, a} + {32'b0, b} + t_bit;
        gpr[rn] = u[31:0];
        t_bit = u[32];
      end
      sh2ae_pkg::CMD_ADDV: begin
        k = sx32(a) + sx32(b);
        gpr[rn] = a + b;
        t_bit = (k > 64'sd2147483647) || (k < -64'sd2147483648);
      end
      sh2ae_pkg::CMD_CMPEQI: t_bit = (a == imm);
      sh2ae_pkg::CMD_CMPEQ: t_bit = (a == b);
      sh2ae_pkg::CMD_CMPHS: t_bit = (a >= b);
      sh2ae_pkg::CMD_CMPGE: t_bit = ($signed(a) >= $signed(b));
      sh2ae_pkg::CMD_CMPHI: t_bit = (a > b);
      sh2ae_pkg::CMD_CMPGT: t_bit = ($signed(a) > $signed(b));
      sh2ae_pkg::CMD_CMPPL: t_bit = ($signed(a) > 0);
      sh2ae_pkg::CMD_CMPPZ: t_bit = ($signed(a) >= 0);
      sh2ae_pkg::CMD_CMPSTR: begin
        r = a ^ b;
        t_bit = (r[7:0] == 0) || (r[15:8] == 0) || (r[23:16] == 0) || (r[31:24] == 0);
      end
      sh2ae_pkg::CMD_DIV1: begin
        oldq = q_bit;
        q_bit = a[31];
        prev_r = {a[30:0], t_bit};
        if (oldq == m_bit) begin
          a = prev_r - b;
          cb = (a > prev_r);
        end else begin
          a = prev_r + b;
          cb = (a < prev_r);
        end
        q_bit = q_bit ^ m_bit ^ cb;
        t_bit = (q_bit == m_bit);
        gpr[rn] = a;
      end
      sh2ae_pkg::CMD_DIV0S: begin
        m_bit = b[31];
        q_bit = a[31];
        t_bit = m_bit ^ q_bit;
      end
      sh2ae_pkg::CMD_DIV0U: begin
        m_bit = 0;
        q_bit = 0;
        t_bit = 0;
      end
      sh2ae_pkg::CMD_DMULS: {mach, macl} = sx32(a) * sx32(b);
      sh2ae_pkg::CMD_DMULU: {mach, macl} = {32'b0, a} * {32'b0, b};
      sh2ae_pkg::CMD_DT: begin
        gpr[rn] = a - 1;
        t_bit = (gpr[rn] == 0);
      end
      sh2ae_pkg::CMD_EXTSB: gpr[rn] = {{24{b[7]}}, b[7:0]};
      sh2ae_pkg::CMD_EXTSW: gpr[rn] = {{16{b[15]}}, b[15:0]};
      sh2ae_pkg::CMD_EXTUB: gpr[rn] = {24'b0, b[7:0]};
      sh2ae_pkg::CMD_EXTUW: gpr[rn] = {16'b0, b[15:0]};
      sh2ae_pkg::CMD_MACL: begin
        res.addr_n = gpr[rn];
        gpr[rn] += 4;
        res.addr_m = gpr[rm];
        gpr[rm] += 4;
        u = sx32(memn) * sx32(memm) + {mach, macl};
        if (sat_mode_i) begin
          if (!u[63] && u > 64'h00007FFFFFFFFFFF) u = 64'h00007FFFFFFFFFFF;
          else if (u[63] && u < 64'hFFFF800000000000) u = 64'hFFFF800000000000;
        end
        {mach, macl} = u;
      end
      sh2ae_pkg::CMD_MACW: begin
        res.addr_n = gpr[rn];
        gpr[rn] += 2;
        res.addr_m = gpr[rm];
        gpr[rm] += 2;
        k = sx16(memn) * sx16(memm);
        if (sat_mode_i) begin
          k += sx32(macl);
          if (k > 64'sd2147483647) begin
            macl = 32'h7FFFFFFF;
            mach[0] = 1'b1;
          end else if (k < -64'sd2147483648) begin
            macl = 32'h80000000;
            mach[0] = 1'b1;
          end else begin
            macl = k[31:0];
          end
        end else begin
          {mach, macl} = {mach, macl} + k;
        end
      end
      sh2ae_pkg::CMD_MULL: macl = a * b;
      sh2ae_pkg::CMD_MULSW: begin
        k = sx16(a) * sx16(b);
        macl = k[31:0];
      end
      sh2ae_pkg::CMD_MULUW: macl = {16'b0, a[15:0]} * {16'b0, b[15:0]};
      sh2ae_pkg::CMD_NEG: gpr[rn] = 0 - b;
      sh2ae_pkg::CMD_NEGC: begin
        gpr[rn] = 0 - b - t_bit;
        t_bit = (b != 0) || t_bit;
      end
      sh2ae_pkg::CMD_SUB: gpr[rn] = a - b;
      sh2ae_pkg::CMD_SUBC: begin
        u = {32'b0, b} + t_bit;
        gpr[rn] = a - b - t_bit;
        t_bit = ({32'b0, a} < u);
      end
      sh2ae_pkg::CMD_SUBV: begin
        k = sx32(a) - sx32(b);
        gpr[rn] = a - b;
        t_bit = (k > 64'sd2147483647) || (k < -64'sd2147483648);
      end
      sh2ae_pkg::CMD_TAS: begin
        res.addr_n = a;
        t_bit = (memn[7:0] == 0);
        res.tas_byte = memn[7:0] | 8'h80;
        res.tas_valid = 1'b1;
      end
      sh2ae_pkg::CMD_XTRCT: gpr[rn] = {b[15:0], a[31:16]};
      default: ;
    endcase
    res.dest_value = gpr[rn];
    res.t_flag = t_bit;
    res.mac_high = mach;
    res.mac_low = macl;
    result_q.push_back(res);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    exec_result_t want, got;
    if (!rst_ni) begin
      foreach (gpr[i]) gpr[i] = '0;
      mach = '0;
      macl = '0;
      t_bit = 0;
      q_bit = 0;
      m_bit = 0;
      result_q.delete();
      fail_count_o = 0;
    end else begin
      if (in_mon.valid && in_mon.ready)
        execute_instr(in_mon.command, in_mon.dest_reg, in_mon.src_reg, in_mon.immediate,
                      in_mon.mem_word_n, in_mon.mem_word_m);
      if (out_mon.valid && out_mon.ready) begin
        got = '{out_mon.dest_value, out_mon.t_flag, out_mon.mac_high, out_mon.mac_low,
                out_mon.access_addr_n, out_mon.access_addr_m, out_mon.tas_write_byte,
                out_mon.tas_write_valid};
        if (result_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10) $display("unexpected result beat %p", got);
        end else begin
          want = result_q.pop_front();
          if (got !== want) begin
            fail_count_o++;
            if (fail_count_o <= 10) $display("mismatch: expected %p actual %p", want, got);
          end
        end
      end
    end
  end
endmodule

[tb/sh2_arith_execute_unit_test.sv]
// Testbench top: drives instructions and S-mode writes into the execute unit, gives the verdict.
`timescale 1ns / 1ps
module sh2_arith_execute_unit_test;
  localparam int CycleLimit = 200000;

  logic clk_i, rst_ni;
  logic psel, penable, pwrite, pready;
  logic [1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic sat_mode;
  int fail_count, pending, cycles;
  bit calm;

  sh2ae_in_if in_ch();
  sh2ae_out_if out_ch();

  sh2_arith_execute_unit u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_ch), .out_o(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  sh2ae_checker u_checker (
    .clk_i(clk_i), .rst_ni(rst_ni), .sat_mode_i(sat_mode), .in_mon(in_ch),
    .out_mon(out_ch), .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
    if (psel && penable && pwrite && pready) sat_mode <= pwdata[0];
  end

  // receiver stalls at random except in calm stretches
  always @(negedge clk_i) out_ch.ready <= calm || ($urandom_range(99) >= 17);

  // leave valid high after a beat; the next idle cycle or wait_idle drops it
  task automatic send_instr(input logic [5:0] cmd, input logic [3:0] rn, input logic [3:0] rm,
                            input logic [7:0] imm, input logic [31:0] mn, input logic [31:0] mm);
    while (!calm && $urandom_range(99) < 17) begin
      in_ch.valid <= 0;
      @(negedge clk_i);
    end
    in_ch.valid <= 1;
    in_ch.command <= cmd;
    in_ch.dest_reg <= rn;
    in_ch.src_reg <= rm;
    in_ch.immediate <= imm;
    in_ch.mem_word_n <= mn;
    in_ch.mem_word_m <= mm;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
  endtask

  task automatic wait_idle;
    in_ch.valid <= 0;
    while (pending != 0) @(negedge clk_i);
    repeat (6) @(negedge clk_i);
  endtask

  task automatic write_sat(input logic val);
    psel <= 1;
    pwrite <= 1;
    paddr <= 0;
    pwdata <= {31'b0, val};
    @(negedge clk_i);
    penable <= 1;
    @(negedge clk_i);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
  endtask

  function automatic logic [31:0] edge_word();
    case ($urandom_range(5))
      0: return 32'h0;
      1: return 32'hFFFFFFFF;
      2: return 32'h7FFFFFFF;
      3: return 32'h80000000;
      default: return $urandom();
    endcase
  endfunction

  task automatic random_phase(input int count);
    logic [5:0] cmd;
    for (int i = 0; i < count; i++) begin
      calm = (i >= count / 2) && (i < count / 2 + 40);
      cmd = ($urandom_range(19) == 0) ? 6'($urandom_range(63, 36)) : 6'($urandom_range(35));
      send_instr(cmd, 4'($urandom_range(15)), 4'($urandom_range(15)), 8'($urandom()),
                 edge_word(), edge_word());
    end
    calm = 0;
  endtask

  initial begin
    cycles = 0;
    calm = 0;
    sat_mode = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    in_ch.valid = 0; in_ch.command = sh2ae_pkg::CMD_MOVT; in_ch.dest_reg = 0;
    in_ch.src_reg = 0;
    in_ch.immediate = 0; in_ch.mem_word_n = 0; in_ch.mem_word_m = 0;
    out_ch.ready = 0;
    rst_ni = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;
    // seed registers with extremes, then walk every command once
    send_instr(sh2ae_pkg::CMD_ADDI, 4'd1, 4'd0, 8'h80, 32'd0, 32'd0);
    send_instr(sh2ae_pkg::CMD_ADDI, 4'd2, 4'd0, 8'h7F, 32'd0, 32'd0);
    send_instr(sh2ae_pkg::CMD_XTRCT, 4'd3, 4'd1, 8'd0, 32'd0, 32'd0);
    send_instr(sh2ae_pkg::CMD_DIV0S, 4'd1, 4'd2, 8'd0, 32'd0, 32'd0);
    for (int c = 0; c <= 35; c++)
      send_instr(6'(c), 4'(1 + c % 3), (c % 5 == 0) ? 4'(1 + c % 3) : 4'd2, 8'(c * 37),
                 (c % 2) ? 32'h7FFFFFFF : 32'h80000000, 32'h80000001);
    send_instr(6'd63, 4'd0, 4'd0, 8'd0, 32'd0, 32'd0);
    wait_idle();
    write_sat(1);
    send_instr(sh2ae_pkg::CMD_MACL, 4'd4, 4'd4, 8'd0, 32'h7FFFFFFF, 32'h7FFFFFFF);
    send_instr(sh2ae_pkg::CMD_MACL, 4'd4, 4'd5, 8'd0, 32'h80000000, 32'h7FFFFFFF);
    send_instr(sh2ae_pkg::CMD_MACW, 4'd4, 4'd4, 8'd0, 32'h8000, 32'h8000);
    send_instr(sh2ae_pkg::CMD_MACW, 4'd5, 4'd4, 8'd0, 32'h7FFF, 32'h8000);
    random_phase(150);
    wait_idle();
    write_sat(0);
    random_phase(150);
    wait_idle();
    write_sat(1);
    random_phase(100);
    wait_idle();
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

[files.f]
+incdir+src
src/sh2ae_pkg.sv
src/sh2ae_if.sv
src/sh2ae_front.sv
src/sh2ae_queue.sv
src/sh2ae_back.sv
src/sh2_arith_execute_unit.sv
tb/sh2ae_checker.sv
tb/sh2_arith_execute_unit_test.sv
